@@ sv/cpbd_pkg.sv @@
`default_nettype none

package cpbd_pkg;

  // Configuration register layout.
  localparam int unsigned CfgW    = 17;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_MIN_CYCLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CYCLE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SPLIT_CYCLE = 2'd2;

  localparam logic [CfgW-1:0] MIN_CYCLE_RST   = 17'd2983;
  localparam logic [CfgW-1:0] MAX_CYCLE_RST   = 17'd23864;
  localparam logic [CfgW-1:0] SPLIT_CYCLE_RST = 17'd8949;

  // Block framing.
  localparam logic [7:0] SYNC_BYTE = 8'h3c;

  // Result byte kinds.
  localparam logic [2:0] KIND_TYPE     = 3'd0;
  localparam logic [2:0] KIND_SIZE     = 3'd1;
  localparam logic [2:0] KIND_DATA     = 3'd2;
  localparam logic [2:0] KIND_CHECKSUM = 3'd3;
  localparam logic [2:0] KIND_TRUNC    = 3'd4;

  // Depth of the event queue between pulse front end and block back end.
  localparam int unsigned QueueDepth = 2;

  // One event from the front end: either a decoded bit or an end of tape.
  typedef struct packed {
    logic eot;
    logic bit_val;
  } ev_t;

endpackage : cpbd_pkg

`default_nettype wire

@@ sv/cpbd_front.sv @@
`default_nettype none

module cpbd_front #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [cpbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [cpbd_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                         accept_i,
  input  wire logic                         pulse_phase_i,
  input  wire logic [WIDTH_BITS-1:0]        pulse_width_i,
  input  wire logic                         end_of_tape_i,
  output logic                              push_o,
  output cpbd_pkg::ev_t                     push_ev_o
);

  localparam int unsigned SumW = WIDTH_BITS + 1;
  localparam int unsigned CmpW = (SumW > cpbd_pkg::CfgW) ? SumW : cpbd_pkg::CfgW;

  logic [cpbd_pkg::CfgW-1:0] min_cycle_q, max_cycle_q, split_cycle_q;
  logic [WIDTH_BITS-1:0]     prev_width_q, prev_width_d;
  logic                      primed_q, primed_d;
  logic [CmpW-1:0]           cycle;
  logic                      in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_cycle_q   <= cpbd_pkg::MIN_CYCLE_RST;
      max_cycle_q   <= cpbd_pkg::MAX_CYCLE_RST;
      split_cycle_q <= cpbd_pkg::SPLIT_CYCLE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cpbd_pkg::CFG_MIN_CYCLE:   min_cycle_q   <= cfg_data_i;
        cpbd_pkg::CFG_MAX_CYCLE:   max_cycle_q   <= cfg_data_i;
        cpbd_pkg::CFG_SPLIT_CYCLE: split_cycle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cycle    = CmpW'(prev_width_q) + CmpW'(pulse_width_i);
  assign in_range = pulse_phase_i && !(cycle < CmpW'(min_cycle_q))
                    && !(cycle > CmpW'(max_cycle_q));

  always_comb begin
    prev_width_d      = prev_width_q;
    primed_d          = primed_q;
    push_o            = 1'b0;
    push_ev_o.eot     = end_of_tape_i;
    push_ev_o.bit_val = (cycle < CmpW'(split_cycle_q));
    if (accept_i) begin
      if (end_of_tape_i) begin
        prev_width_d = '0;
        primed_d     = 1'b0;
        push_o       = 1'b1;
      end else if (!primed_q) begin
        prev_width_d = pulse_width_i;
        primed_d     = 1'b1;
      end else begin
        prev_width_d = pulse_width_i;
        if (in_range) begin
          // A decoded bit consumes the pair; the next pulse primes it again.
          primed_d = 1'b0;
          push_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_width_q <= '0;
      primed_q     <= 1'b0;
    end else begin
      prev_width_q <= prev_width_d;
      primed_q     <= primed_d;
    end
  end

endmodule : cpbd_front

`default_nettype wire

@@ sv/cpbd_queue.sv @@
`default_nettype none

module cpbd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire cpbd_pkg::ev_t  push_ev_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output cpbd_pkg::ev_t       ev_o
);

  localparam int unsigned Depth = cpbd_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cpbd_pkg::ev_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign ev_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule : cpbd_queue

`default_nettype wire

@@ sv/cpbd_back.sv @@
`default_nettype none

module cpbd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          ev_valid_i,
  input  wire cpbd_pkg::ev_t ev_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         byte_value_o,
  output logic [2:0]         byte_kind_o,
  output logic [7:0]         data_index_o,
  output logic               block_last_o,
  output logic               checksum_ok_o
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_TYPE,
    ST_SIZE,
    ST_DATA,
    ST_CHECK
  } stage_e;

  stage_e     stage_q, stage_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] bits_q, bits_d;
  logic [7:0] remain_q, remain_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_q, count_d;
  logic [7:0] shifted;
  logic       emit;
  logic [7:0] res_value;
  logic [2:0] res_kind;
  logic [7:0] res_index;
  logic       res_last;
  logic       res_ok;
  logic       out_valid_q;
  logic [7:0] value_q;
  logic [2:0] kind_q;
  logic [7:0] index_q;
  logic       last_q;
  logic       ok_q;

  // An event is taken whenever the output register is free or being drained.
  assign pop_o   = ev_valid_i && (!out_valid_q || out_ready_i);
  assign shifted = {ev_i.bit_val, shift_q[7:1]};

  always_comb begin
    stage_d   = stage_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    remain_d  = remain_q;
    sum_d     = sum_q;
    count_d   = count_q;
    emit      = 1'b0;
    res_value = shifted;
    res_kind  = cpbd_pkg::KIND_TYPE;
    res_index = '0;
    res_last  = 1'b0;
    res_ok    = 1'b0;
    if (pop_o) begin
      if (ev_i.eot) begin
        if (stage_q != ST_HUNT) begin
          emit      = 1'b1;
          res_value = '0;
          res_kind  = cpbd_pkg::KIND_TRUNC;
          res_last  = 1'b1;
        end
        stage_d  = ST_HUNT;
        shift_d  = '0;
        bits_d   = '0;
        remain_d = '0;
        count_d  = '0;
      end else if (stage_q == ST_HUNT) begin
        shift_d = shifted;
        if (shifted == cpbd_pkg::SYNC_BYTE) begin
          stage_d = ST_TYPE;
          shift_d = '0;
          bits_d  = '0;
        end
      end else if (bits_q != 3'd7) begin
        shift_d = shifted;
        bits_d  = bits_q + 3'd1;
      end else begin
        bits_d  = '0;
        shift_d = '0;
        emit    = 1'b1;
        unique case (stage_q)
          ST_TYPE: begin
            sum_d   = shifted;
            stage_d = ST_SIZE;
          end
          ST_SIZE: begin
            res_kind = cpbd_pkg::KIND_SIZE;
            sum_d    = sum_q + shifted;
            remain_d = shifted;
            count_d  = '0;
            stage_d  = (shifted != '0) ? ST_DATA : ST_CHECK;
          end
          ST_DATA: begin
            res_kind  = cpbd_pkg::KIND_DATA;
            res_index = count_q;
            sum_d     = sum_q + shifted;
            count_d   = count_q + 8'd1;
            remain_d  = remain_q - 8'd1;
            if (remain_q == 8'd1) begin
              stage_d = ST_CHECK;
            end
          end
          default: begin
            res_kind = cpbd_pkg::KIND_CHECKSUM;
            res_last = 1'b1;
            res_ok   = (sum_q == shifted);
            stage_d  = ST_HUNT;
            remain_d = '0;
            count_d  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= ST_HUNT;
      shift_q     <= '0;
      bits_q      <= '0;
      remain_q    <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      kind_q      <= '0;
      index_q     <= '0;
      last_q      <= 1'b0;
      ok_q        <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      if (emit) begin
        out_valid_q <= 1'b1;
        value_q     <= res_value;
        kind_q      <= res_kind;
        index_q     <= res_index;
        last_q      <= res_last;
        ok_q        <= res_ok;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_value_o  = value_q;
  assign byte_kind_o   = kind_q;
  assign data_index_o  = index_q;
  assign block_last_o  = last_q;
  assign checksum_ok_o = ok_q;

endmodule : cpbd_back

`default_nettype wire

@@ sv/cassette_pulse_block_decoder.sv @@
// Throughput: one pulse per cycle while the two-entry queue is not full; the front end
// pairs and classifies pulses combinationally, and the back end takes one bit event per
// cycle while its output register is free or drained, registering each completed result.
// Reset (rst_ni low, asynchronous): pair unprimed, hunting for sync, queue empty,
// output empty, cycle bounds back to their default values.
`default_nettype none

module cassette_pulse_block_decoder #(
  parameter int unsigned WIDTH_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [cpbd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [cpbd_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         pulse_phase_i,
  input  wire logic [WIDTH_BITS-1:0]        pulse_width_i,
  input  wire logic                         end_of_tape_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [7:0]                        byte_value_o,
  output logic [2:0]                        byte_kind_o,
  output logic [7:0]                        data_index_o,
  output logic                              block_last_o,
  output logic                              checksum_ok_o
);

  logic          q_full, q_valid, push, pop, accept;
  cpbd_pkg::ev_t push_ev, pop_ev;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign accept      = in_valid_i && in_ready_o;

  cpbd_front #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .pulse_phase_i (pulse_phase_i),
    .pulse_width_i (pulse_width_i),
    .end_of_tape_i (end_of_tape_i),
    .push_o        (push),
    .push_ev_o     (push_ev)
  );

  cpbd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_ev_i (push_ev),
    .pop_i     (pop),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .ev_o      (pop_ev)
  );

  cpbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ev_valid_i    (q_valid),
    .ev_i          (pop_ev),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_value_o  (byte_value_o),
    .byte_kind_o   (byte_kind_o),
    .data_index_o  (data_index_o),
    .block_last_o  (block_last_o),
    .checksum_ok_o (checksum_ok_o)
  );

  // The block ends only on a checksum byte or on a truncation.
  a_last_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_last_o |->
      (byte_kind_o == cpbd_pkg::KIND_CHECKSUM) || (byte_kind_o == cpbd_pkg::KIND_TRUNC))
    else $error("block_last on a byte that does not end a block");

  a_ok_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && checksum_ok_o |-> byte_kind_o == cpbd_pkg::KIND_CHECKSUM)
    else $error("checksum_ok set on a byte other than the checksum");

  a_index_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (data_index_o != 8'd0) |-> byte_kind_o == cpbd_pkg::KIND_DATA)
    else $error("nonzero data_index on a non-data byte");

  // A queued event is always drained when the output register is free.
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !out_valid_o |-> pop)
    else $error("queued event not taken while output is free");

endmodule : cassette_pulse_block_decoder

`default_nettype wire

@@ tb/tb_cassette_pulse_block_decoder.sv @@
`timescale 1ns / 100ps

module tb_cassette_pulse_block_decoder;

  localparam int PW = 16;
  localparam int MAX_WIDTH = (1 << PW) - 1;
  localparam int MAX_CYCLE_SUM = 2 * MAX_WIDTH;
  localparam int SETTLE_CYCLES = 8;
  localparam int TIMEOUT_NS = 4_000_000;
  localparam logic [cpbd_pkg::CfgIdxW-1:0] CFG_RESERVED = 2'd3;

  typedef enum logic [2:0] {
    STAGE_HUNT,
    STAGE_TYPE,
    STAGE_SIZE,
    STAGE_DATA,
    STAGE_CHECK
  } stage_e;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] kind;
    logic [7:0] idx;
    logic       last;
    logic       sum_ok;
  } byte_rec_t;

  typedef struct packed {
    logic          phase;
    logic [PW-1:0] width;
    logic          eot;
    logic          typed;
    byte_rec_t     want;
  } pulse_row_t;

  localparam byte_rec_t NO_BYTE = '0;
  localparam byte_rec_t TRUNC_BYTE = '{8'd0, cpbd_pkg::KIND_TRUNC, 8'd0, 1'b1, 1'b0};

  // The opening rows walk the width and phase extremes, then lock onto the sync
  // byte with cycles sitting exactly on the default bounds and the split value.
  // One bit into the type byte the tape ends, which must truncate the block.
  localparam int DIRECTED_N = 25;
  localparam pulse_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{1'b1, 16'hffff, 1'b1, 1'b0, NO_BYTE},
    '{1'b1, 16'h0000, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'hffff, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'h0000, 1'b1, 1'b0, NO_BYTE},
    '{1'b0, 16'd11932, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd11932, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd4474, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd4475, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'd0, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd2983, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd4474, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd4474, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd1000, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'd3000, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd4000, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'd3000, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd2000, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'd10000, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd10000, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'd5000, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd5000, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'd2000, 1'b0, 1'b0, NO_BYTE},
    '{1'b1, 16'd2000, 1'b0, 1'b0, NO_BYTE},
    '{1'b0, 16'h1234, 1'b1, 1'b1, TRUNC_BYTE},
    '{1'b1, 16'h5a5a, 1'b1, 1'b0, NO_BYTE}
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [cpbd_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [cpbd_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         pulse_phase_i = 1'b0;
  logic [PW-1:0]                pulse_width_i = '0;
  logic                         end_of_tape_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [7:0]                   byte_value_o;
  logic [2:0]                   byte_kind_o;
  logic [7:0]                   data_index_o;
  logic                         block_last_o;
  logic                         checksum_ok_o;

  // Predictor state and its copy of the cycle bounds.
  logic [cpbd_pkg::CfgW-1:0] min_cycle, max_cycle, split_cycle;
  logic [PW-1:0]             prev_width;
  logic                      pair_primed;
  logic [7:0]                shift_reg;
  logic [2:0]                bit_pos;
  stage_e                    stage;
  logic [7:0]                bytes_left;
  logic [7:0]                byte_sum;
  logic [7:0]                data_pos;

  byte_rec_t expected_bytes [$];
  int        fail_count = 0;
  int        pulse_count = 0;
  bit        sender_gaps = 1'b1;
  bit        sink_stalls = 1'b1;

  cassette_pulse_block_decoder #(
    .WIDTH_BITS(PW)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pulse_phase_i(pulse_phase_i),
    .pulse_width_i(pulse_width_i),
    .end_of_tape_i(end_of_tape_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .byte_value_o (byte_value_o),
    .byte_kind_o  (byte_kind_o),
    .data_index_o (data_index_o),
    .block_last_o (block_last_o),
    .checksum_ok_o(checksum_ok_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void restart_hunt();
    stage = STAGE_HUNT;
    shift_reg = '0;
    bit_pos = '0;
    bytes_left = '0;
    data_pos = '0;
  endfunction

  // Advances the predictor by one pulse; returns 1 when the pulse yields a byte.
  function automatic bit decode_pulse(input logic phase, input logic [PW-1:0] width,
                                      input logic eot, output byte_rec_t rec);
    logic [PW:0] cyc;
    logic [7:0]  b;
    bit          in_block;
    rec = '0;
    if (eot) begin
      in_block = (stage != STAGE_HUNT);
      pair_primed = 1'b0;
      prev_width = '0;
      restart_hunt();
      rec.kind = cpbd_pkg::KIND_TRUNC;
      rec.last = 1'b1;
      return in_block;
    end
    if (!pair_primed) begin
      prev_width = width;
      pair_primed = 1'b1;
      return 1'b0;
    end
    cyc = {1'b0, prev_width} + {1'b0, width};
    prev_width = width;
    if (!phase || cyc < min_cycle || cyc > max_cycle) return 1'b0;
    pair_primed = 1'b0;
    shift_reg = {(cyc < split_cycle), shift_reg[7:1]};
    if (stage == STAGE_HUNT) begin
      if (shift_reg == cpbd_pkg::SYNC_BYTE) begin
        stage = STAGE_TYPE;
        shift_reg = '0;
        bit_pos = '0;
      end
      return 1'b0;
    end
    if (bit_pos != 3'd7) begin
      bit_pos = bit_pos + 3'd1;
      return 1'b0;
    end
    bit_pos = '0;
    b = shift_reg;
    shift_reg = '0;
    rec.value = b;
    case (stage)
      STAGE_TYPE: begin
        byte_sum = b;
        stage = STAGE_SIZE;
        rec.kind = cpbd_pkg::KIND_TYPE;
      end
      STAGE_SIZE: begin
        byte_sum = byte_sum + b;
        bytes_left = b;
        data_pos = '0;
        stage = (b != 8'd0) ? STAGE_DATA : STAGE_CHECK;
        rec.kind = cpbd_pkg::KIND_SIZE;
      end
      STAGE_DATA: begin
        rec.kind = cpbd_pkg::KIND_DATA;
        rec.idx = data_pos;
        byte_sum = byte_sum + b;
        data_pos = data_pos + 8'd1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) stage = STAGE_CHECK;
      end
      default: begin
        rec.kind = cpbd_pkg::KIND_CHECKSUM;
        rec.last = 1'b1;
        rec.sum_ok = (byte_sum == b);
        restart_hunt();
      end
    endcase
    return 1'b1;
  endfunction

  // Chooses a cycle width that decodes as the wanted bit under the current bounds.
  // Where no such width exists, any width is returned and the bit is simply lost.
  function automatic int pick_cycle(input logic bit_val);
    int mn, mx, sp, lo, hi;
    mn = int'(min_cycle);
    mx = int'(max_cycle);
    sp = int'(split_cycle);
    if (bit_val) begin
      lo = mn;
      hi = (sp - 1 < mx) ? sp - 1 : mx;
    end else begin
      lo = (sp > mn) ? sp : mn;
      hi = mx;
    end
    if (hi > MAX_CYCLE_SUM) hi = MAX_CYCLE_SUM;
    if (lo > hi) return $urandom_range(0, MAX_CYCLE_SUM);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic send_pulse(input logic phase, input logic [PW-1:0] width, input logic eot,
                            input bit typed = 1'b0, input byte_rec_t typed_rec = '0);
    byte_rec_t rec;
    bit        has_byte;
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pulse_phase_i <= phase;
    pulse_width_i <= width;
    end_of_tape_i <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_byte = decode_pulse(phase, width, eot, rec);
    if (typed) expected_bytes.push_back(typed_rec);
    else if (has_byte) expected_bytes.push_back(rec);
    pulse_count++;
  endtask

  task automatic send_bit(input logic bit_val);
    int c, w1;
    c = pick_cycle(bit_val);
    w1 = $urandom_range((c > MAX_WIDTH) ? c - MAX_WIDTH : 0, (c < MAX_WIDTH) ? c : MAX_WIDTH);
    // Low-phase pulses never complete a cycle; they only replace the held width.
    repeat (($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 0)
      send_pulse(1'b0, PW'($urandom_range(0, MAX_WIDTH)), 1'b0);
    send_pulse(pair_primed ? 1'b0 : 1'($urandom_range(0, 1)), PW'(w1), 1'b0);
    send_pulse(1'b1, PW'(c - w1), 1'b0);
  endtask

  task automatic send_block(input int size);
    logic [7:0] frame [$];
    logic [7:0] sum;
    int         cut;
    if (stage != STAGE_HUNT)
      send_pulse(1'($urandom_range(0, 1)), PW'($urandom_range(0, MAX_WIDTH)), 1'b1);
    frame.push_back(cpbd_pkg::SYNC_BYTE);
    frame.push_back(8'($urandom_range(0, 255)));
    frame.push_back(8'(size));
    sum = frame[1] + frame[2];
    repeat (size) begin
      frame.push_back(8'($urandom_range(0, 255)));
      sum = sum + frame[$];
    end
    frame.push_back(($urandom_range(0, 3) == 0) ? sum + 8'($urandom_range(1, 255)) : sum);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(9, frame.size() * 8 - 1) : -1;
    for (int i = 0; i < frame.size() * 8; i++) begin
      if (i == cut) begin
        send_pulse(1'($urandom_range(0, 1)), PW'($urandom_range(0, MAX_WIDTH)), 1'b1);
        return;
      end
      send_bit(frame[i / 8][i % 8]);
    end
  endtask

  task automatic run_traffic(input int n_pulses, input bit with_full_block);
    int stop_at;
    int pick;
    stop_at = pulse_count + n_pulses;
    if (with_full_block) send_block(24);
    while (pulse_count < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_block(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 8))
          send_pulse(1'($urandom_range(0, 1)),
                     PW'($urandom_range(0, 1) ? $urandom_range(0, MAX_WIDTH)
                                              : $urandom_range(0, 12000)),
                     $urandom_range(0, 19) == 0);
      end else begin
        send_pulse(1'($urandom_range(0, 1)), PW'($urandom_range(0, MAX_WIDTH)), 1'b1);
      end
    end
  endtask

  // Holds the sender off until every expected byte is out, then lets any pulse
  // still inside the block settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [cpbd_pkg::CfgIdxW-1:0] idx,
                           input logic [cpbd_pkg::CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      cpbd_pkg::CFG_MIN_CYCLE:   min_cycle = value;
      cpbd_pkg::CFG_MAX_CYCLE:   max_cycle = value;
      cpbd_pkg::CFG_SPLIT_CYCLE: split_cycle = value;
      default: ;
    endcase
  endtask

  task automatic set_cycle_bounds(input logic [cpbd_pkg::CfgW-1:0] lo,
                                  input logic [cpbd_pkg::CfgW-1:0] hi,
                                  input logic [cpbd_pkg::CfgW-1:0] split);
    drain_results();
    // The unused index must leave all three bounds alone.
    write_cfg(CFG_RESERVED, cpbd_pkg::CfgW'($urandom));
    write_cfg(cpbd_pkg::CFG_MIN_CYCLE, lo);
    write_cfg(cpbd_pkg::CFG_MAX_CYCLE, hi);
    write_cfg(cpbd_pkg::CFG_SPLIT_CYCLE, split);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int mn, sp;
    min_cycle = cpbd_pkg::MIN_CYCLE_RST;
    max_cycle = cpbd_pkg::MAX_CYCLE_RST;
    split_cycle = cpbd_pkg::SPLIT_CYCLE_RST;
    prev_width = '0;
    pair_primed = 1'b0;
    byte_sum = '0;
    restart_hunt();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i])
      send_pulse(DIRECTED_ROWS[i].phase, DIRECTED_ROWS[i].width, DIRECTED_ROWS[i].eot,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    run_traffic(250, 1'b0);

    // Every cycle width is accepted; this phase also carries one long block.
    set_cycle_bounds('0, '1, cpbd_pkg::CfgW'($urandom_range(4000, 30000)));
    run_traffic(450, 1'b1);

    // Crossed bounds: nothing may decode.
    set_cycle_bounds('1, '0, cpbd_pkg::SPLIT_CYCLE_RST);
    run_traffic(100, 1'b0);

    sender_gaps = 1'b0;
    set_cycle_bounds(cpbd_pkg::CfgW'(5000), cpbd_pkg::CfgW'(7000), cpbd_pkg::CfgW'(6000));
    run_traffic(200, 1'b0);

    sender_gaps = 1'b1;
    sink_stalls = 1'b0;
    set_cycle_bounds('0, '1, '0);
    run_traffic(60, 1'b0);
    set_cycle_bounds('0, '1, '1);
    run_traffic(60, 1'b0);

    // Closing stretch at full rate on both sides.
    sender_gaps = 1'b0;
    mn = $urandom_range(0, 8000);
    sp = mn + $urandom_range(1000, 20000);
    set_cycle_bounds(cpbd_pkg::CfgW'(mn), cpbd_pkg::CfgW'(sp + $urandom_range(1000, 40000)),
                     cpbd_pkg::CfgW'(sp));
    run_traffic(350, 1'b0);

    drain_results();
    if (fail_count == 0) begin
      $display("cassette_pulse_block_decoder: match");
    end else begin
      $display("cassette_pulse_block_decoder: mismatch");
    end
    $finish;
  end

  initial begin : sink_ready
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_stalls && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Every output transfer is matched against the oldest predicted byte.
  always @(posedge clk_i) begin : check_bytes
    byte_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: byte_value %0h byte_kind %0d", byte_value_o, byte_kind_o);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (byte_value_o !== want.value) begin
          $error("byte_value: expected %0h, actual %0h", want.value, byte_value_o);
          fail_count++;
        end
        if (byte_kind_o !== want.kind) begin
          $error("byte_kind: expected %0d, actual %0d", want.kind, byte_kind_o);
          fail_count++;
        end
        if (data_index_o !== want.idx) begin
          $error("data_index: expected %0d, actual %0d", want.idx, data_index_o);
          fail_count++;
        end
        if (block_last_o !== want.last) begin
          $error("block_last: expected %0b, actual %0b", want.last, block_last_o);
          fail_count++;
        end
        if (checksum_ok_o !== want.sum_ok) begin
          $error("checksum_ok: expected %0b, actual %0b", want.sum_ok, checksum_ok_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("cassette_pulse_block_decoder: mismatch");
    $finish;
  end

endmodule
